>>> hw/rtl/ecs_pkg.sv
package ecs_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam int unsigned DEF_CHANNELS           = 4;
  localparam int unsigned DEF_PERIOD_AUTOCAL_ONE = 10;
  localparam int unsigned DEF_PERIOD_AUTOCAL_TWO = 10;
  localparam int unsigned DEF_PERIOD_SETUP       = 10;
  localparam int unsigned DEF_PERIOD_RUN         = 10;

  // setup one loads a short first period, then reloads with the long one
  localparam logic [SAMPLE_W-1:0] SETUP1_ENTRY_PERIOD  = 16'd1;
  localparam logic [SAMPLE_W-1:0] SETUP1_RELOAD_PERIOD = 16'd10;
  localparam logic [SAMPLE_W-1:0] LOW_REF_MARGIN       = 16'd100;
  localparam logic [7:0]          DOT_LIMIT            = 8'd200;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_CAL1   = 3'd1,
    ST_CAL2   = 3'd2,
    ST_SAVE   = 3'd3,
    ST_LOAD   = 3'd4,
    ST_SETUP  = 3'd5,
    ST_SETUP1 = 3'd6,
    ST_RUN    = 3'd7
  } ecs_state_t;

  typedef enum logic [1:0] {
    MSG_NONE          = 2'd0,
    MSG_AUTOCAL_START = 2'd1,
    MSG_SETUP_START   = 2'd2,
    MSG_SETUP_DONE    = 2'd3
  } ecs_msg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SETUP     = 3'd0,
    CFG_TARGET_RUN       = 3'd1,
    CFG_TARGET_AUTO      = 3'd2,
    CFG_WINDOW_DELTA     = 3'd3,
    CFG_SATURATION_LEVEL = 3'd4,
    CFG_REGULATION_EN    = 3'd5
  } ecs_cfg_idx_t;

  typedef struct packed {
    logic [2:0]          state_code;
    logic                run_mode;
    logic [SAMPLE_W-1:0] target_value;
    logic                time_base_load;
    logic [SAMPLE_W-1:0] time_base_value;
    logic                init_table;
    logic                save_table;
    logic                load_table;
    ecs_msg_t            message_event;
    logic                progress_dot;
  } ecs_result_t;

endpackage

>>> hw/rtl/electrode_calibration_sequencer.sv
// A transfer accepted at the input is held in the input register, then the result
// register; one tick is accepted every cycle unless the output stalls.
// The only loop is the sequencer state, updated once per tick as it leaves the
// input register. Synchronous active-low reset: state init, entry pending,
// target zero, dot counter zero, both stages empty, registers at reset values.
module electrode_calibration_sequencer
  import ecs_pkg::*;
#(
  parameter int unsigned CHANNELS           = DEF_CHANNELS,
  parameter int unsigned PERIOD_AUTOCAL_ONE = DEF_PERIOD_AUTOCAL_ONE,
  parameter int unsigned PERIOD_AUTOCAL_TWO = DEF_PERIOD_AUTOCAL_TWO,
  parameter int unsigned PERIOD_SETUP       = DEF_PERIOD_SETUP,
  parameter int unsigned PERIOD_RUN         = DEF_PERIOD_RUN
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample_0,
  input  logic [SAMPLE_W-1:0]  in_sample_1,
  input  logic [SAMPLE_W-1:0]  in_sample_2,
  input  logic [SAMPLE_W-1:0]  in_sample_3,
  input  logic                 in_flash_valid,
  input  logic                 in_time_base_zero,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_state_code,
  output logic                 out_run_mode,
  output logic [SAMPLE_W-1:0]  out_target_value,
  output logic                 out_time_base_load,
  output logic [SAMPLE_W-1:0]  out_time_base_value,
  output logic                 out_init_table,
  output logic                 out_save_table,
  output logic                 out_load_table,
  output logic [1:0]           out_message_event,
  output logic                 out_progress_dot
);

  localparam int unsigned NCHAN = (CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS :
                                  ((CHANNELS < 1) ? 1 : CHANNELS);
  localparam logic [SAMPLE_W-1:0] P_CAL1  = SAMPLE_W'(PERIOD_AUTOCAL_ONE);
  localparam logic [SAMPLE_W-1:0] P_CAL2  = SAMPLE_W'(PERIOD_AUTOCAL_TWO);
  localparam logic [SAMPLE_W-1:0] P_SETUP = SAMPLE_W'(PERIOD_SETUP);
  localparam logic [SAMPLE_W-1:0] P_RUN   = SAMPLE_W'(PERIOD_RUN);

  // configuration registers
  logic [SAMPLE_W-1:0] target_setup_r, target_run_r, target_auto_r;
  logic [SAMPLE_W-1:0] window_delta_r, saturation_level_r;
  logic                regulation_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_setup_r      <= '0;
      target_run_r        <= '0;
      target_auto_r       <= '0;
      window_delta_r      <= '0;
      saturation_level_r  <= '1;
      regulation_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_SETUP:     target_setup_r      <= cfg_data;
        CFG_TARGET_RUN:       target_run_r        <= cfg_data;
        CFG_TARGET_AUTO:      target_auto_r       <= cfg_data;
        CFG_WINDOW_DELTA:     window_delta_r      <= cfg_data;
        CFG_SATURATION_LEVEL: saturation_level_r  <= cfg_data;
        CFG_REGULATION_EN:    regulation_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r [MAX_CHANNELS];
  logic                s1_flash_r, s1_tbz_r;
  logic                s1_move, in_take;

  assign s1_move  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r[0] <= in_sample_0;
      s1_sample_r[1] <= in_sample_1;
      s1_sample_r[2] <= in_sample_2;
      s1_sample_r[3] <= in_sample_3;
      s1_flash_r     <= in_flash_valid;
      s1_tbz_r       <= in_time_base_zero;
    end
  end

  // sequencer state
  ecs_state_t          state_r, state_nxt, prev_r;
  logic [SAMPLE_W-1:0] target_r, target_nxt;
  logic [7:0]          dot_cnt_r, dot_cnt_nxt;
  logic                entry;

  assign entry = (prev_r != state_r);

  // window and recalibration checks
  logic [SAMPLE_W:0]   win_hi;
  logic [SAMPLE_W-1:0] win_lo, low_ref, win_target;
  logic                win_ok, recal;
  logic [NCHAN-1:0]    in_win, sat, low;

  always_comb begin
    win_target = target_r;
    if (entry) begin
      case (state_r)
        ST_CAL1, ST_SETUP:         win_target = target_setup_r;
        ST_CAL2, ST_SETUP1, ST_RUN: win_target = target_run_r;
        default:                   win_target = target_r;
      endcase
    end
  end

  always_comb begin
    win_hi  = {1'b0, win_target} + {1'b0, window_delta_r};
    win_lo  = (win_target > window_delta_r) ? win_target - window_delta_r : '0;
    low_ref = (target_auto_r > LOW_REF_MARGIN) ? target_auto_r - LOW_REF_MARGIN : '0;
    for (int i = 0; i < NCHAN; i++) begin
      in_win[i] = ({1'b0, s1_sample_r[i]} < win_hi) && (s1_sample_r[i] > win_lo);
      sat[i]    = (s1_sample_r[i] >= saturation_level_r);
      low[i]    = (s1_sample_r[i] < low_ref);
    end
    win_ok = &in_win;
    recal  = (&sat) || (|low);
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    target_nxt = win_target;
    case (state_r)
      ST_INIT:   state_nxt = s1_flash_r ? ST_LOAD : ST_CAL1;
      ST_CAL1:   if (win_ok) state_nxt = ST_CAL2;
      ST_CAL2:   if (win_ok) state_nxt = ST_SAVE;
      ST_SAVE:   state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_SETUP;
      ST_SETUP:  if (win_ok) state_nxt = ST_SETUP1;
      ST_SETUP1: if (win_ok) state_nxt = ST_RUN;
      ST_RUN:    if (recal && regulation_enable_r) state_nxt = ST_SETUP1;
      default:   state_nxt = state_r;
    endcase
  end

  // outputs
  ecs_result_t         res;
  logic                timed;
  logic [SAMPLE_W-1:0] entry_val, reload_val;
  logic [7:0]          dot_inc;

  always_comb begin
    res        = '0;
    timed      = 1'b1;
    entry_val  = '0;
    reload_val = '0;
    case (state_r)
      ST_INIT: begin
        timed          = 1'b0;
        res.init_table = entry;
      end
      ST_CAL1: begin
        entry_val  = P_CAL1;
        reload_val = P_CAL1;
        if (entry) res.message_event = MSG_AUTOCAL_START;
      end
      ST_CAL2: begin
        entry_val  = P_CAL2;
        reload_val = P_CAL2;
      end
      ST_SAVE: begin
        timed          = 1'b0;
        res.save_table = 1'b1;
      end
      ST_LOAD: begin
        timed          = 1'b0;
        res.load_table = 1'b1;
      end
      ST_SETUP: begin
        entry_val  = P_SETUP;
        reload_val = P_SETUP;
      end
      ST_SETUP1: begin
        entry_val  = SETUP1_ENTRY_PERIOD;
        reload_val = SETUP1_RELOAD_PERIOD;
        // done wins over started when both land in one tick
        if (win_ok) begin
          res.message_event = MSG_SETUP_DONE;
        end else if (entry) begin
          res.message_event = MSG_SETUP_START;
        end
      end
      default: begin
        entry_val  = P_RUN;
        reload_val = P_RUN;
      end
    endcase

    if (timed && entry) begin
      res.time_base_load  = 1'b1;
      res.time_base_value = entry_val;
    end else if (timed && s1_tbz_r) begin
      res.time_base_load  = 1'b1;
      res.time_base_value = reload_val;
    end

    dot_inc     = dot_cnt_r + 8'd1;
    dot_cnt_nxt = dot_cnt_r;
    if (state_nxt != ST_RUN) begin
      if (dot_inc > DOT_LIMIT) begin
        dot_cnt_nxt      = '0;
        res.progress_dot = 1'b1;
      end else begin
        dot_cnt_nxt = dot_inc;
      end
    end

    res.state_code   = (state_nxt == ST_RUN) ? 3'(ST_SETUP1) : 3'(state_nxt);
    res.run_mode     = (state_nxt == ST_RUN);
    res.target_value = target_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      prev_r    <= ST_RUN;  // differs from init so the init entry fires
      target_r  <= '0;
      dot_cnt_r <= '0;
    end else if (s1_move) begin
      state_r   <= state_nxt;
      prev_r    <= state_r;
      target_r  <= target_nxt;
      dot_cnt_r <= dot_cnt_nxt;
    end
  end

  // result stage
  logic        out_valid_r;
  ecs_result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_state_code      = res_r.state_code;
  assign out_run_mode        = res_r.run_mode;
  assign out_target_value    = res_r.target_value;
  assign out_time_base_load  = res_r.time_base_load;
  assign out_time_base_value = res_r.time_base_value;
  assign out_init_table      = res_r.init_table;
  assign out_save_table      = res_r.save_table;
  assign out_load_table      = res_r.load_table;
  assign out_message_event   = res_r.message_event;
  assign out_progress_dot    = res_r.progress_dot;

endmodule
